// ----- rtl/core/gcbm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package gcbm_pkg;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_READ = 1'b1;

   // matches at or above this distance never count
   localparam logic [15:0] DIST_LIMIT = 16'd10000;
   localparam int          DIST_W     = 14;

   typedef struct packed {
      logic        mode;
      logic [9:0]  key_x;
      logic [9:0]  key_y;
      logic [15:0] query_index;
      logic [15:0] train_index;
      logic [15:0] distance;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  cell_column;
      logic [3:0]  cell_row;
      logic [15:0] best_query;
      logic [15:0] best_train;
      logic [15:0] best_dist;
   } rsp_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [15:0]       query;
      logic [15:0]       train;
   } entry_type;

endpackage
`default_nettype wire

// ----- rtl/core/gcbm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gcbm_ram #(
   parameter int  WIDTH  = 46,
   parameter int  DEPTH  = 100,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/grid_cell_best_match_selector_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Keeps the smallest-distance match per grid cell and reads the cells back in
// column-major order. A load item that falls inside the grid with a distance
// below 10000 holds busy through S_LOAD after it is accepted (cell entry read from
// the RAM at accept, then compare and write back); any other load leaves busy
// low. A read item walks the valid bits one cell per cycle from where the last
// read stopped: busy while it skips empty cells, then through the S_SCAN hit and
// S_READ when a cell is found, and through the scan to the end of the grid for
// the closing read that reports found=0 and clears the store. Each read item gives
// exactly one result, in the first cycle in which busy is low again, on rsp_strobe
// for a single cycle; the receiver cannot stall it. Load items produce no result.
module grid_cell_best_match_selector_unit #(
   parameter int IMAGE_WIDTH    = 640,
   parameter int IMAGE_HEIGHT   = 480,
   parameter int GRID_COLS      = 10,
   parameter int GRID_ROW_COUNT = 10
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire gcbm_pkg::req_type req_item,
   output logic                  rsp_strobe,
   output gcbm_pkg::rsp_type     rsp_item
);
   import gcbm_pkg::*;

   localparam int CELL_W     = IMAGE_WIDTH / GRID_COLS;
   localparam int CELL_H     = IMAGE_HEIGHT / GRID_ROW_COUNT;
   localparam int X_LIMIT    = CELL_W * GRID_COLS;
   localparam int Y_LIMIT    = CELL_H * GRID_ROW_COUNT;
   localparam int CELL_COUNT = GRID_COLS * GRID_ROW_COUNT;
   localparam int IDX_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int PTR_W      = $clog2(CELL_COUNT + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LOAD = 4'b0010,
      S_SCAN = 4'b0100,
      S_READ = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [3:0]        scan_col_ff, scan_col_in;
   logic [3:0]        scan_row_ff, scan_row_in;
   logic [CELL_COUNT-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]  ld_idx_ff;
   entry_type         ld_entry_ff;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_item_ff, rsp_item_in;

   logic [3:0]        ld_col, ld_row;
   logic              ld_ok;
   logic [IDX_W-1:0]  ld_idx;
   logic              accept;
   logic              scan_end;
   logic [IDX_W-1:0]  scan_idx;
   logic              scan_hit;
   logic [3:0]        next_col, next_row;

   logic              ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   entry_type         ram_rd_data;
   logic              ld_better;

   assign accept = start && (state_ff == S_IDLE);

   // cell lookup by constant thresholds, a priority encode per axis
   always_comb begin
      ld_col = '0;
      ld_row = '0;
      for (int k = 1; k < GRID_COLS; k++) begin
         if ({1'b0, req_item.key_x} >= 11'(k * CELL_W)) begin
            ld_col = 4'(k);
         end
      end
      for (int k = 1; k < GRID_ROW_COUNT; k++) begin
         if ({1'b0, req_item.key_y} >= 11'(k * CELL_H)) begin
            ld_row = 4'(k);
         end
      end
   end

   assign ld_ok = ({1'b0, req_item.key_x} < 11'(X_LIMIT))
               && ({1'b0, req_item.key_y} < 11'(Y_LIMIT))
               && (req_item.distance < DIST_LIMIT);
   assign ld_idx = IDX_W'(32'(ld_col) * GRID_ROW_COUNT + 32'(ld_row));

   assign scan_end = (ptr_ff == PTR_W'(CELL_COUNT));
   assign scan_idx = ptr_ff[IDX_W-1:0];
   assign scan_hit = !scan_end && valid_ff[scan_idx];

   always_comb begin
      if (scan_row_ff == 4'(GRID_ROW_COUNT - 1)) begin
         next_row = '0;
         next_col = scan_col_ff + 4'd1;
      end else begin
         next_row = scan_row_ff + 4'd1;
         next_col = scan_col_ff;
      end
   end

   // the entry read at accept is compared in the following cycle
   assign ld_better = !valid_ff[ld_idx_ff]
                   || (ld_entry_ff.distance < ram_rd_data.distance);

   assign ram_rd_en = (accept && req_item.mode == MODE_LOAD && ld_ok)
                   || (state_ff == S_SCAN && scan_hit);
   assign ram_rd_addr = (state_ff == S_IDLE) ? ld_idx : scan_idx;
   assign ram_wr_en = (state_ff == S_LOAD) && ld_better;

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      scan_col_in   = scan_col_ff;
      scan_row_in   = scan_row_ff;
      valid_in      = valid_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_item.mode == MODE_READ) begin
                  state_in = S_SCAN;
               end else if (ld_ok) begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            if (ld_better) begin
               valid_in[ld_idx_ff] = 1'b1;
            end
            state_in = S_IDLE;
         end
         S_SCAN: begin
            if (scan_end) begin
               // frame done: report empty and clear the store
               valid_in      = '0;
               ptr_in        = '0;
               scan_col_in   = '0;
               scan_row_in   = '0;
               rsp_strobe_in = 1'b1;
               rsp_item_in   = '0;
               state_in      = S_IDLE;
            end else if (scan_hit) begin
               state_in = S_READ;
            end else begin
               ptr_in      = ptr_ff + PTR_W'(1);
               scan_col_in = next_col;
               scan_row_in = next_row;
            end
         end
         S_READ: begin
            rsp_strobe_in           = 1'b1;
            rsp_item_in.found       = 1'b1;
            rsp_item_in.cell_column = scan_col_ff;
            rsp_item_in.cell_row    = scan_row_ff;
            rsp_item_in.best_query  = ram_rd_data.query;
            rsp_item_in.best_train  = ram_rd_data.train;
            rsp_item_in.best_dist   = {2'b00, ram_rd_data.distance};
            ptr_in      = ptr_ff + PTR_W'(1);
            scan_col_in = next_col;
            scan_row_in = next_row;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ptr_ff        <= '0;
         scan_col_ff   <= '0;
         scan_row_ff   <= '0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         scan_col_ff   <= scan_col_in;
         scan_row_ff   <= scan_row_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      if (accept) begin
         ld_idx_ff            <= ld_idx;
         ld_entry_ff.distance <= req_item.distance[DIST_W-1:0];
         ld_entry_ff.query    <= req_item.query_index;
         ld_entry_ff.train    <= req_item.train_index;
      end
   end

   gcbm_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(CELL_COUNT)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ld_idx_ff),
      .wr_data (ld_entry_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule
`default_nettype wire
